// File: rtl/sts_pkg.sv
package sts_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int BOUND_W     = $clog2(TABLE_DEPTH + 1);

   // Field widths fixed by the interface
   localparam int INDEX_W = 8;
   localparam int CSR_W   = 9;
   localparam int DATA_W  = 32;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [INDEX_W-1:0]        entry_index;
      logic signed [DATA_W-1:0]  entry_value;
      logic signed [DATA_W-1:0]  search_key;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] found_index;
   } rsp_type;

   // Finished search handed from the controller to the output stage
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } done_type;

   // Table memory access issued by the controller
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_RESULT
   } state_type;

endpackage

// File: rtl/sts_ram.sv
module sts_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sts_ctrl.sv
module sts_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  sts_pkg::req_type           req_data,
   input  logic [sts_pkg::CSR_W-1:0]  entries_in_use,
   input  logic [sts_pkg::DATA_W-1:0] rd_data,
   input  logic                       slot_free,
   output sts_pkg::ram_req_type       ram_req,
   output sts_pkg::done_type          done
);

   import sts_pkg::*;

   state_type                state_ff, state_in;
   logic [BOUND_W-1:0]       lo_ff, lo_in;
   logic [BOUND_W-1:0]       end_ff, end_in;
   logic [ADDR_W-1:0]        mid_ff, mid_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic                     found_ff, found_in;
   logic [INDEX_W-1:0]       index_ff, index_in;

   logic                     accept;
   logic                     is_search;
   logic [BOUND_W-1:0]       count_sat;
   logic [ADDR_W-1:0]        first_mid;
   logic signed [DATA_W-1:0] probe;
   logic                     key_lt;
   logic                     key_gt;
   logic                     hit;
   logic [BOUND_W-1:0]       lo_next;
   logic [BOUND_W-1:0]       end_next;
   logic [BOUND_W:0]         mid_sum;
   logic [ADDR_W-1:0]        next_mid;
   logic                     range_empty;

   assign accept    = req_valid && req_ready;
   assign is_search = (req_data.op == OP_SEARCH);

   // Clamp the entry count to the table depth
   assign count_sat = (32'(entries_in_use) > TABLE_DEPTH) ? BOUND_W'(TABLE_DEPTH)
                                                          : BOUND_W'(entries_in_use);

   // First probe: floor((0 + count - 1) / 2)
   assign first_mid = ADDR_W'((count_sat - BOUND_W'(1)) >> 1);

   // Compare the probed entry and narrow the window [lo, end)
   assign probe  = $signed(rd_data);
   assign key_lt = (key_ff < probe);
   assign key_gt = (key_ff > probe);
   assign hit    = !key_lt && !key_gt;

   always_comb begin
      lo_next  = lo_ff;
      end_next = end_ff;
      if (key_lt) begin
         end_next = BOUND_W'(mid_ff);
      end else if (key_gt) begin
         lo_next = BOUND_W'(mid_ff) + BOUND_W'(1);
      end
   end

   assign range_empty = (lo_next >= end_next);
   assign mid_sum     = {1'b0, lo_next} + {1'b0, end_next} - (BOUND_W + 1)'(1);
   assign next_mid    = ADDR_W'(mid_sum >> 1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_search) begin
               state_in = (count_sat == '0) ? ST_RESULT : ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (hit || range_empty) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath next values
   always_comb begin
      req_ready       = 1'b0;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = ADDR_W'(req_data.entry_index);
      ram_req.wr_data = req_data.entry_value;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = next_mid;
      done.valid      = 1'b0;
      done.rsp        = '{found: found_ff, found_index: index_ff};
      lo_in           = lo_ff;
      end_in          = end_ff;
      mid_in          = mid_ff;
      key_in          = key_ff;
      found_in        = found_ff;
      index_in        = index_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept && !is_search) begin
               ram_req.wr_en = (32'(req_data.entry_index) < TABLE_DEPTH);
            end
            if (accept && is_search) begin
               lo_in           = '0;
               end_in          = count_sat;
               mid_in          = first_mid;
               key_in          = req_data.search_key;
               found_in        = 1'b0;
               index_in        = '0;
               ram_req.rd_addr = first_mid;
               ram_req.rd_en   = (count_sat != '0);
            end
         end
         ST_LOOK: begin
            lo_in  = lo_next;
            end_in = end_next;
            if (hit) begin
               found_in = 1'b1;
               index_in = INDEX_W'(mid_ff);
            end else if (!range_empty) begin
               mid_in        = next_mid;
               ram_req.rd_en = 1'b1;
            end
         end
         ST_RESULT: begin
            done.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Search datapath
   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      end_ff   <= end_in;
      mid_ff   <= mid_in;
      key_ff   <= key_in;
      found_ff <= found_in;
      index_ff <= index_in;
   end

endmodule

// File: rtl/sorted_table_binary_search.sv
// Write request: the table entry is written at the accept edge.
// Search request: the accept issues the first read, then the sequencer makes one probe per
//   cycle (floor(log2 n)+1, at most 9 for 256 entries) through the single table read port,
//   then holds its result state until the response register is free; one search at a time.
// Reset clears the control state, the response valid flag and the entry count (zero);
//   table contents stay undefined until written, with no clearing pass.
module sorted_table_binary_search (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  sts_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output sts_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [sts_pkg::CSR_W-1:0] csr_wdata
);

   import sts_pkg::*;

   logic [CSR_W-1:0]  entries_ff, entries_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              slot_free;
   ram_req_type       ram_req;
   done_type          done;
   logic [DATA_W-1:0] rd_data;

   // Entry count register
   assign entries_in = csr_we ? csr_wdata : entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
      end else begin
         entries_ff <= entries_in;
      end
   end

   // Search sequencer
   sts_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .entries_in_use (entries_ff),
      .rd_data        (rd_data),
      .slot_free      (slot_free),
      .ram_req        (ram_req),
      .done           (done)
   );

   // Table memory
   sts_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (rd_data)
   );

   // Response register: load a finished search when the slot is free, drop on accept
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done.valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done.rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/sts_checker.sv
module sts_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input sts_pkg::req_type          req_data,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input sts_pkg::rsp_type          rsp_data
);

   import sts_pkg::*;

   logic       search_acc;
   logic       rsp_acc;
   logic [1:0] pending_ff, pending_in;

   assign search_acc = req_valid && req_ready && (req_data.op == OP_SEARCH);
   assign rsp_acc    = rsp_valid && rsp_ready;

   // Track searches accepted but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (search_acc && !rsp_acc) begin
         pending_in = pending_ff + 2'd1;
      end else if (!search_acc && rsp_acc) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Every response answers an earlier search
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without pending search");

   // A search occupies the block: no request taken in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      search_acc |=> !req_ready)
      else $error("request accepted during search");

   // A miss reports index zero
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.found_index == '0)
      else $error("miss with nonzero index");

   // At most one search in the sequencer and one in the response register
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many searches outstanding");

endmodule

bind sorted_table_binary_search sts_checker u_sts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
